// ===== design/ooktx_pkg.sv =====
// ============================================================================
// ooktx_pkg
// Shared types and constants for the on-off-keyed pulse message transmitter.
// ============================================================================
package ooktx_pkg;

    // Input beat: one command to the transmitter
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] index;
        logic [7:0] value;
    } in_t;

    // Result beat: line and busy status after the command
    typedef struct packed {
        logic line_level;
        logic busy_res;
    } out_t;

    // Command codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // Configuration register indexes
    localparam logic [3:0] REG_LOW_COUNT      = 4'd0;
    localparam logic [3:0] REG_HIGH_COUNT     = 4'd1;
    localparam logic [3:0] REG_TRAIL_COUNT    = 4'd2;
    localparam logic [3:0] REG_GAP_COUNT      = 4'd3;
    localparam logic [3:0] REG_GAP_MULTIPLIER = 4'd4;
    localparam logic [3:0] REG_REPEAT_TOTAL   = 4'd5;
    localparam logic [3:0] REG_INVERT_LINE    = 4'd6;
    localparam logic [3:0] REG_TRANSLATE      = 4'd7;

    // Configuration reset values
    localparam logic [7:0] LOW_COUNT_RST      = 8'd7;
    localparam logic [7:0] HIGH_COUNT_RST     = 8'd4;
    localparam logic [7:0] TRAIL_COUNT_RST    = 8'd2;
    localparam logic [7:0] GAP_COUNT_RST      = 8'd72;
    localparam logic [7:0] GAP_MULTIPLIER_RST = 8'd0;
    localparam logic [5:0] REPEAT_TOTAL_RST   = 6'd12;
    localparam logic       INVERT_LINE_RST    = 1'b0;
    localparam logic       TRANSLATE_RST      = 1'b1;

    // Period counter value after reset
    localparam logic [7:0] PERIOD_LEFT_RST = 8'd3;

    // First bit of a byte, MSB first
    localparam logic [7:0] BIT_SELECT_FIRST = 8'h80;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_MSGSTART  = 3'd1,
        PH_BYTESTART = 3'd2,
        PH_SENDBYTE  = 3'd3,
        PH_MSGEND    = 3'd4,
        PH_GAPSTART  = 3'd5,
        PH_GAPEND    = 3'd6
    } phase_t;

    // Map a nibble to its line code byte
    function automatic logic [7:0] code_lookup(input logic [3:0] nibble);
        logic [7:0] code;
        case (nibble)
            4'h0:    code = 8'hF6;
            4'h1:    code = 8'hEE;
            4'h2:    code = 8'hED;
            4'h3:    code = 8'hEB;
            4'h4:    code = 8'hDE;
            4'h5:    code = 8'hDD;
            4'h6:    code = 8'hDB;
            4'h7:    code = 8'hBE;
            4'h8:    code = 8'hBD;
            4'h9:    code = 8'hBB;
            4'hA:    code = 8'hB7;
            4'hB:    code = 8'h7E;
            4'hC:    code = 8'h7D;
            4'hD:    code = 8'h7B;
            4'hE:    code = 8'h77;
            default: code = 8'h6F;
        endcase
        return code;
    endfunction

endpackage

// ===== design/ook_pulse_message_transmitter.sv =====
// ============================================================================
// ook_pulse_message_transmitter
// On-off-keyed pulse message transmitter with a small message store.
// ============================================================================
// Each input beat is a tick, a message byte write or a start request; every
// beat yields exactly one result beat carrying the line level and busy flag
// as they stand after that beat. The block takes one beat per clock while
// s_ready is high: the state update is a single pass of logic from the
// accepted beat into the state registers, and the result is registered into
// the output buffer. A two-entry output buffer holds results while the downstream
// side stalls, so s_ready drops only when both entries are full. The
// configuration port is always ready and writes one register per beat.
module ook_pulse_message_transmitter #(
    parameter int MSG_BYTES = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    // command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  ooktx_pkg::in_t     s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output ooktx_pkg::out_t    m_data,
    // configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int IDX_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    // configuration registers
    logic [7:0] low_count_reg;
    logic [7:0] high_count_reg;
    logic [7:0] trail_count_reg;
    logic [7:0] gap_count_reg;
    logic [7:0] gap_multiplier_reg;
    logic [5:0] repeat_total_reg;
    logic       invert_line_reg;
    logic       translate_reg;

    // sequencer state
    ooktx_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       period_left_reg, period_left_next;
    logic [7:0]       bit_select_reg, bit_select_next;
    logic [IDX_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]       repeats_done_reg, repeats_done_next;
    logic [7:0]       gaps_left_reg, gaps_left_next;
    logic             active_reg, active_next;
    logic             line_on_reg, line_on_next;

    logic [7:0] message_store [MSG_BYTES];

    // output buffer
    ooktx_pkg::out_t main_reg, skid_reg, result_next;
    logic            main_valid_reg, skid_valid_reg;

    logic             in_fire, out_fire;
    logic             tick_fire, adv;
    logic [7:0]       period_dec;
    logic [7:0]       cur_byte;
    logic [IDX_W:0]   pos_inc;
    logic             last_byte;
    logic             last_bit;
    logic [7:0]       repeats_inc;
    logic             wr_en;
    logic [7:0]       wr_byte;

    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = main_valid_reg;
    assign m_data    = main_reg;

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_count_reg      <= ooktx_pkg::LOW_COUNT_RST;
            high_count_reg     <= ooktx_pkg::HIGH_COUNT_RST;
            trail_count_reg    <= ooktx_pkg::TRAIL_COUNT_RST;
            gap_count_reg      <= ooktx_pkg::GAP_COUNT_RST;
            gap_multiplier_reg <= ooktx_pkg::GAP_MULTIPLIER_RST;
            repeat_total_reg   <= ooktx_pkg::REPEAT_TOTAL_RST;
            invert_line_reg    <= ooktx_pkg::INVERT_LINE_RST;
            translate_reg      <= ooktx_pkg::TRANSLATE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ooktx_pkg::REG_LOW_COUNT:      low_count_reg      <= cfg_data;
                ooktx_pkg::REG_HIGH_COUNT:     high_count_reg     <= cfg_data;
                ooktx_pkg::REG_TRAIL_COUNT:    trail_count_reg    <= cfg_data;
                ooktx_pkg::REG_GAP_COUNT:      gap_count_reg      <= cfg_data;
                ooktx_pkg::REG_GAP_MULTIPLIER: gap_multiplier_reg <= cfg_data;
                ooktx_pkg::REG_REPEAT_TOTAL:   repeat_total_reg   <= cfg_data[5:0];
                ooktx_pkg::REG_INVERT_LINE:    invert_line_reg    <= cfg_data[0];
                ooktx_pkg::REG_TRANSLATE:      translate_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode the beat and the shared conditions of the sequencer
    assign tick_fire   = in_fire && (s_data.mode == ooktx_pkg::MODE_TICK) && active_reg;
    assign period_dec  = period_left_reg - 8'd1;
    assign adv         = tick_fire && (period_dec != trail_count_reg)
                         && (period_dec == 8'd0);
    assign cur_byte    = message_store[byte_pos_reg];
    assign pos_inc     = {1'b0, byte_pos_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign last_byte   = pos_inc >= (IDX_W+1)'(MSG_BYTES);
    assign last_bit    = (bit_select_reg >> 1) == 8'd0;
    assign repeats_inc = repeats_done_reg + 8'd1;

    assign wr_en   = in_fire && (s_data.mode == ooktx_pkg::MODE_WRITE)
                     && ({1'b0, s_data.index} < 5'(MSG_BYTES));
    assign wr_byte = translate_reg ? ooktx_pkg::code_lookup(s_data.value[3:0])
                                   : s_data.value;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (adv) begin
            unique case (phase_reg)
                ooktx_pkg::PH_IDLE:      phase_next = ooktx_pkg::PH_MSGSTART;
                ooktx_pkg::PH_MSGSTART:  phase_next = ooktx_pkg::PH_BYTESTART;
                ooktx_pkg::PH_BYTESTART: phase_next = ooktx_pkg::PH_SENDBYTE;
                ooktx_pkg::PH_SENDBYTE: begin
                    if (last_bit) begin
                        phase_next = last_byte ? ooktx_pkg::PH_MSGEND
                                               : ooktx_pkg::PH_BYTESTART;
                    end
                end
                ooktx_pkg::PH_MSGEND:    phase_next = ooktx_pkg::PH_GAPSTART;
                ooktx_pkg::PH_GAPSTART: begin
                    if (gaps_left_reg == 8'd0) begin
                        phase_next = ooktx_pkg::PH_GAPEND;
                    end
                end
                ooktx_pkg::PH_GAPEND: begin
                    phase_next = (repeats_inc >= {2'b00, repeat_total_reg})
                                 ? ooktx_pkg::PH_IDLE : ooktx_pkg::PH_MSGSTART;
                end
                default:                 phase_next = ooktx_pkg::PH_IDLE;
            endcase
        end
    end

    // counters, line and busy flag
    always_comb begin
        period_left_next  = period_left_reg;
        bit_select_next   = bit_select_reg;
        byte_pos_next     = byte_pos_reg;
        repeats_done_next = repeats_done_reg;
        gaps_left_next    = gaps_left_reg;
        active_next       = active_reg;
        line_on_next      = line_on_reg;

        if (in_fire && (s_data.mode == ooktx_pkg::MODE_START)) begin
            active_next = 1'b1;
        end

        if (tick_fire) begin
            period_left_next = period_dec;
            if (period_dec == trail_count_reg) begin
                line_on_next = 1'b0;
            end else if (period_dec == 8'd0) begin
                period_left_next = high_count_reg;
                unique case (phase_reg)
                    ooktx_pkg::PH_IDLE: begin
                        repeats_done_next = 8'd0;
                    end
                    ooktx_pkg::PH_MSGSTART: begin
                        line_on_next  = 1'b1;
                        byte_pos_next = '0;
                    end
                    ooktx_pkg::PH_BYTESTART: begin
                        line_on_next    = 1'b1;
                        bit_select_next = ooktx_pkg::BIT_SELECT_FIRST;
                    end
                    ooktx_pkg::PH_SENDBYTE: begin
                        if ((cur_byte & bit_select_reg) != 8'd0) begin
                            line_on_next = 1'b1;
                        end else begin
                            period_left_next = low_count_reg;
                        end
                        bit_select_next = bit_select_reg >> 1;
                        if (last_bit && !last_byte) begin
                            byte_pos_next = pos_inc[IDX_W-1:0];
                        end
                    end
                    ooktx_pkg::PH_MSGEND: begin
                        line_on_next   = 1'b1;
                        gaps_left_next = gap_multiplier_reg;
                    end
                    ooktx_pkg::PH_GAPSTART: begin
                        period_left_next = gap_count_reg;
                        if (gaps_left_reg != 8'd0) begin
                            gaps_left_next = gaps_left_reg - 8'd1;
                        end
                    end
                    ooktx_pkg::PH_GAPEND: begin
                        repeats_done_next = repeats_inc;
                        if (repeats_inc >= {2'b00, repeat_total_reg}) begin
                            active_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end

        result_next.line_level = line_on_next ^ invert_line_reg;
        result_next.busy_res   = active_next;
    end

    // hold sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= ooktx_pkg::PH_IDLE;
            period_left_reg  <= ooktx_pkg::PERIOD_LEFT_RST;
            bit_select_reg   <= '0;
            byte_pos_reg     <= '0;
            repeats_done_reg <= '0;
            gaps_left_reg    <= '0;
            active_reg       <= 1'b0;
            line_on_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            period_left_reg  <= period_left_next;
            bit_select_reg   <= bit_select_next;
            byte_pos_reg     <= byte_pos_next;
            repeats_done_reg <= repeats_done_next;
            gaps_left_reg    <= gaps_left_next;
            active_reg       <= active_next;
            line_on_reg      <= line_on_next;
        end
    end

    // write message bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MSG_BYTES; i++) begin
                message_store[i] <= 8'd0;
            end
        end else if (wr_en) begin
            message_store[s_data.index[IDX_W-1:0]] <= wr_byte;
        end
    end

    // buffer result beats: main entry drives the port, skid entry absorbs a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= in_fire;
                skid_reg       <= result_next;
            end else begin
                main_valid_reg <= in_fire;
                main_reg       <= result_next;
            end
        end else if (in_fire) begin
            if (!main_valid_reg) begin
                main_valid_reg <= 1'b1;
                main_reg       <= result_next;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= result_next;
            end
        end
    end

endmodule

// ===== bench/tb_ook_pulse_message_transmitter.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_ook_pulse_message_transmitter
// Self-checking bench for the on-off-keyed pulse message transmitter.
// ============================================================================
// Drives command beats (ticks, message byte writes, start requests and the
// unused code) through the valid/ready input, and predicts the line level and
// busy flag after each accepted beat with a behavioral copy of the
// sequencer. Every result beat is compared against the oldest prediction.
// Several register settings are loaded between phases while the pipe is
// empty, including the counter extremes, raw and translated bytes and an
// inverted line. Both sides idle at random, except in one steady phase.
module tb_ook_pulse_message_transmitter;

    localparam int MSG_BYTES = 10;

    // Unused command code, treated as a status read
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Line codes for nibbles 15 down to 0
    localparam logic [127:0] NIBBLE_CODES = {
        8'h6F, 8'h77, 8'h7B, 8'h7D, 8'h7E, 8'hB7, 8'hBB, 8'hBD,
        8'hBE, 8'hDB, 8'hDD, 8'hDE, 8'hEB, 8'hED, 8'hEE, 8'hF6
    };

    typedef struct {
        logic [7:0] low_count;
        logic [7:0] high_count;
        logic [7:0] trail_count;
        logic [7:0] gap_count;
        logic [7:0] gap_multiplier;
        logic [5:0] repeat_total;
        logic       invert_line;
        logic       translate;
    } tx_setting_t;

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    ooktx_pkg::in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    ooktx_pkg::out_t m_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [3:0]      cfg_index;
    logic [7:0]      cfg_data;

    // Predicted transmitter state
    tx_setting_t       tx_cfg;
    logic [7:0]        tx_store [MSG_BYTES];
    ooktx_pkg::phase_t tx_phase;
    logic [7:0]        tx_period;
    logic [7:0]        tx_bit_sel;
    logic [3:0]        tx_byte_pos;
    logic [7:0]        tx_rounds_sent;
    logic [7:0]        tx_gaps_left;
    logic              tx_active;
    logic              tx_line_on;

    ooktx_pkg::out_t expected_status_q [$];

    logic steady;
    int   mismatch_count;
    int   cmd_count;
    int   write_count;
    int   start_count;
    int   result_count;
    int   frames_done;
    int   settings_loaded;

    ook_pulse_message_transmitter #(
        .MSG_BYTES(MSG_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void reset_transmitter();
        tx_cfg.low_count      = ooktx_pkg::LOW_COUNT_RST;
        tx_cfg.high_count     = ooktx_pkg::HIGH_COUNT_RST;
        tx_cfg.trail_count    = ooktx_pkg::TRAIL_COUNT_RST;
        tx_cfg.gap_count      = ooktx_pkg::GAP_COUNT_RST;
        tx_cfg.gap_multiplier = ooktx_pkg::GAP_MULTIPLIER_RST;
        tx_cfg.repeat_total   = ooktx_pkg::REPEAT_TOTAL_RST;
        tx_cfg.invert_line    = ooktx_pkg::INVERT_LINE_RST;
        tx_cfg.translate      = ooktx_pkg::TRANSLATE_RST;
        for (int i = 0; i < MSG_BYTES; i++) tx_store[i] = 8'h00;
        tx_phase       = ooktx_pkg::PH_IDLE;
        tx_period      = ooktx_pkg::PERIOD_LEFT_RST;
        tx_bit_sel     = 8'h00;
        tx_byte_pos    = 4'd0;
        tx_rounds_sent = 8'd0;
        tx_gaps_left   = 8'd0;
        tx_active      = 1'b0;
        tx_line_on     = 1'b0;
    endfunction

    // Move the sequencer one step at the end of a period
    function automatic void advance_sequence();
        logic [7:0] cur;
        tx_period = tx_cfg.high_count;
        case (tx_phase)
            ooktx_pkg::PH_IDLE: begin
                tx_rounds_sent = 8'd0;
                tx_phase       = ooktx_pkg::PH_MSGSTART;
            end
            ooktx_pkg::PH_MSGSTART: begin
                tx_line_on  = 1'b1;
                tx_byte_pos = 4'd0;
                tx_phase    = ooktx_pkg::PH_BYTESTART;
            end
            ooktx_pkg::PH_BYTESTART: begin
                tx_line_on = 1'b1;
                tx_bit_sel = ooktx_pkg::BIT_SELECT_FIRST;
                tx_phase   = ooktx_pkg::PH_SENDBYTE;
            end
            ooktx_pkg::PH_SENDBYTE: begin
                cur = (tx_byte_pos < MSG_BYTES) ? tx_store[tx_byte_pos] : 8'h00;
                // a one bit pulses the line, a zero bit reloads the period from the low count
                if ((cur & tx_bit_sel) != 8'h00) tx_line_on = 1'b1;
                else tx_period = tx_cfg.low_count;
                tx_bit_sel = tx_bit_sel >> 1;
                if (tx_bit_sel == 8'h00) begin
                    if (tx_byte_pos + 1 >= MSG_BYTES) begin
                        tx_phase = ooktx_pkg::PH_MSGEND;
                    end else begin
                        tx_byte_pos = tx_byte_pos + 4'd1;
                        tx_phase    = ooktx_pkg::PH_BYTESTART;
                    end
                end
            end
            ooktx_pkg::PH_MSGEND: begin
                tx_line_on   = 1'b1;
                tx_phase     = ooktx_pkg::PH_GAPSTART;
                tx_gaps_left = tx_cfg.gap_multiplier;
            end
            ooktx_pkg::PH_GAPSTART: begin
                tx_period = tx_cfg.gap_count;
                if (tx_gaps_left == 8'd0) tx_phase = ooktx_pkg::PH_GAPEND;
                else tx_gaps_left = tx_gaps_left - 8'd1;
            end
            ooktx_pkg::PH_GAPEND: begin
                tx_rounds_sent = tx_rounds_sent + 8'd1;
                if (tx_rounds_sent >= {2'b00, tx_cfg.repeat_total}) begin
                    tx_active = 1'b0;
                    tx_phase  = ooktx_pkg::PH_IDLE;
                    frames_done++;
                end else begin
                    tx_phase = ooktx_pkg::PH_MSGSTART;
                end
            end
            default: tx_phase = ooktx_pkg::PH_IDLE;
        endcase
    endfunction

    // Apply one command beat and return the status it leaves behind
    function automatic ooktx_pkg::out_t apply_command(ooktx_pkg::in_t cmd);
        ooktx_pkg::out_t status;
        case (cmd.mode)
            ooktx_pkg::MODE_TICK: begin
                if (tx_active) begin
                    tx_period = tx_period - 8'd1;
                    if (tx_period == tx_cfg.trail_count) tx_line_on = 1'b0;
                    else if (tx_period == 8'd0) advance_sequence();
                end
            end
            ooktx_pkg::MODE_WRITE: begin
                if (cmd.index < MSG_BYTES)
                    tx_store[cmd.index] = tx_cfg.translate ?
                        NIBBLE_CODES[{cmd.value[3:0], 3'b000} +: 8] : cmd.value;
            end
            ooktx_pkg::MODE_START: tx_active = 1'b1;
            default: ;
        endcase
        status.line_level = tx_line_on ^ tx_cfg.invert_line;
        status.busy_res   = tx_active;
        return status;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s (got %0d, expected %0d)", $time, what, got, want);
        mismatch_count++;
    endtask

    // Check each result beat, then pick the next ready level
    always @(posedge aclk) begin : check_status
        ooktx_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_status_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", int'(m_data), 0);
            end else begin
                want = expected_status_q.pop_front();
                if (m_data.line_level !== want.line_level)
                    report_mismatch("line_level", int'(m_data.line_level),
                                    int'(want.line_level));
                if (m_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", int'(m_data.busy_res),
                                    int'(want.busy_res));
            end
        end
        m_ready <= aresetn && (steady || $urandom_range(99) >= 21);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    function automatic ooktx_pkg::in_t make_cmd(logic [1:0] mode, logic [3:0] index,
                                                logic [7:0] value);
        ooktx_pkg::in_t cmd;
        cmd.mode  = mode;
        cmd.index = index;
        cmd.value = value;
        return cmd;
    endfunction

    // Send one command beat; valid stays high afterwards until the caller
    // either sends again or drops it
    task automatic send_cmd(input ooktx_pkg::in_t cmd);
        while (!steady && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_status_q.push_back(apply_command(cmd));
        cmd_count++;
        if (cmd.mode == ooktx_pkg::MODE_WRITE) write_count++;
        if (cmd.mode == ooktx_pkg::MODE_START) start_count++;
    endtask

    // Drop valid and hold until every predicted beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
    endtask

    // Write all eight registers back to back while the pipe is empty
    task automatic load_settings(input tx_setting_t s);
        logic [3:0] idx;
        logic [7:0] data;
        wait_drained();
        for (int i = 0; i < 8; i++) begin
            idx = i[3:0];
            case (idx)
                ooktx_pkg::REG_LOW_COUNT: begin
                    data = s.low_count;
                    tx_cfg.low_count = data;
                end
                ooktx_pkg::REG_HIGH_COUNT: begin
                    data = s.high_count;
                    tx_cfg.high_count = data;
                end
                ooktx_pkg::REG_TRAIL_COUNT: begin
                    data = s.trail_count;
                    tx_cfg.trail_count = data;
                end
                ooktx_pkg::REG_GAP_COUNT: begin
                    data = s.gap_count;
                    tx_cfg.gap_count = data;
                end
                ooktx_pkg::REG_GAP_MULTIPLIER: begin
                    data = s.gap_multiplier;
                    tx_cfg.gap_multiplier = data;
                end
                ooktx_pkg::REG_REPEAT_TOTAL: begin
                    data = {2'b00, s.repeat_total};
                    tx_cfg.repeat_total = s.repeat_total;
                end
                ooktx_pkg::REG_INVERT_LINE: begin
                    data = {7'd0, s.invert_line};
                    tx_cfg.invert_line = s.invert_line;
                end
                default: begin
                    data = {7'd0, s.translate};
                    tx_cfg.translate = s.translate;
                end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic tx_setting_t make_setting(
        logic [7:0] low, logic [7:0] high, logic [7:0] trail, logic [7:0] gap,
        logic [7:0] gap_mul, logic [5:0] repeats, logic invert, logic xlate);
        tx_setting_t s;
        s.low_count      = low;
        s.high_count     = high;
        s.trail_count    = trail;
        s.gap_count      = gap;
        s.gap_multiplier = gap_mul;
        s.repeat_total   = repeats;
        s.invert_line    = invert;
        s.translate      = xlate;
        return s;
    endfunction

    // Mostly ticks so that frames run deep, with writes, starts and noise
    function automatic ooktx_pkg::in_t random_command();
        ooktx_pkg::in_t cmd;
        int             r;
        r = $urandom_range(99);
        cmd.value = 8'($urandom_range(255));
        cmd.index = 4'($urandom_range(15));
        if (r < 84) begin
            cmd.mode = ooktx_pkg::MODE_TICK;
        end else if (r < 94) begin
            cmd.mode = ooktx_pkg::MODE_WRITE;
            if ($urandom_range(9) != 0) cmd.index = 4'($urandom_range(MSG_BYTES - 1));
        end else if (r < 98) begin
            cmd.mode = ooktx_pkg::MODE_START;
        end else begin
            cmd.mode = MODE_UNUSED;
        end
        return cmd;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_cmd(random_command());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ticks and the unused code while idle leave everything as it was
    task automatic test_idle_commands();
        send_cmd(make_cmd(ooktx_pkg::MODE_TICK, 4'd0, 8'h00));
        send_cmd(make_cmd(MODE_UNUSED, 4'd15, 8'hFF));
        send_cmd(make_cmd(ooktx_pkg::MODE_TICK, 4'd15, 8'hFF));
    endtask

    // Translated writes at both ends of the store, and out-of-range indexes
    task automatic test_message_store();
        send_cmd(make_cmd(ooktx_pkg::MODE_WRITE, 4'd0, 8'h00));
        send_cmd(make_cmd(ooktx_pkg::MODE_WRITE, 4'd9, 8'hFF));
        send_cmd(make_cmd(ooktx_pkg::MODE_WRITE, 4'd10, 8'h5A));
        send_cmd(make_cmd(ooktx_pkg::MODE_WRITE, 4'd15, 8'hA5));
        send_cmd(make_cmd(ooktx_pkg::MODE_WRITE, 4'd4, 8'h0B));
    endtask

    // Start, start again while busy, and rewrite the byte being sent
    task automatic test_start_while_active();
        send_cmd(make_cmd(ooktx_pkg::MODE_START, 4'd0, 8'h00));
        send_cmd(make_cmd(ooktx_pkg::MODE_START, 4'd7, 8'h3C));
        for (int i = 0; i < 10; i++) begin
            send_cmd(make_cmd(ooktx_pkg::MODE_TICK, 4'd0, 8'h00));
            if (i == 6) send_cmd(make_cmd(ooktx_pkg::MODE_WRITE, 4'd0, 8'h07));
        end
        send_cmd(make_cmd(MODE_UNUSED, 4'd0, 8'h00));
    endtask

    // Short periods so whole frames complete; pause once with the pipe empty
    task automatic test_short_frames();
        load_settings(make_setting(8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 6'd1, 1'b0, 1'b1));
        send_random(225);
        wait_drained();
        send_random(225);
    endtask

    // Repeat count of zero sends one frame; raw bytes, inverted line
    task automatic test_repeat_zero_raw();
        load_settings(make_setting(8'd1, 8'd2, 8'd1, 8'd1, 8'd0, 6'd0, 1'b1, 1'b0));
        send_random(400);
    endtask

    // Trail of zero holds the counter wrapping; other eight-bit fields at their ends
    task automatic test_trail_zero();
        load_settings(make_setting(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 6'd39, 1'b1, 1'b1));
        send_random(150);
    endtask

    // Zero reload wraps to a full 256-tick period
    task automatic test_zero_period();
        load_settings(make_setting(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 6'd1, 1'b0, 1'b0));
        send_random(200);
    endtask

    // Back-to-back beats on both sides with no idling at all
    task automatic test_steady_traffic();
        load_settings(make_setting(8'd2, 8'd3, 8'd1, 8'd3, 8'd2, 6'd2, 1'b0, 1'b1));
        steady = 1'b1;
        send_random(500);
        steady = 1'b0;
    endtask

    // Back to the reset values
    task automatic test_default_timing();
        load_settings(make_setting(ooktx_pkg::LOW_COUNT_RST, ooktx_pkg::HIGH_COUNT_RST,
                                   ooktx_pkg::TRAIL_COUNT_RST, ooktx_pkg::GAP_COUNT_RST,
                                   ooktx_pkg::GAP_MULTIPLIER_RST,
                                   ooktx_pkg::REPEAT_TOTAL_RST,
                                   ooktx_pkg::INVERT_LINE_RST, ooktx_pkg::TRANSLATE_RST));
        send_random(250);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        mismatch_count  = 0;
        cmd_count       = 0;
        write_count     = 0;
        start_count     = 0;
        result_count    = 0;
        frames_done     = 0;
        settings_loaded = 0;
        reset_transmitter();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_message_store();
        test_start_while_active();
        test_short_frames();
        test_repeat_zero_raw();
        test_trail_zero();
        test_zero_period();
        test_steady_traffic();
        test_default_timing();

        // Drain, then idle a little longer for stray beats
        wait_drained();
        repeat (4) @(posedge aclk);

        $display("Ran %0d command beats (%0d byte writes, %0d starts) over %0d settings",
                 cmd_count, write_count, start_count, settings_loaded);
        $display("Checked %0d status beats; %0d transmissions ran through to idle",
                 result_count, frames_done);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("Timed out waiting on the transmitter");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ooktx_pkg.sv
design/ook_pulse_message_transmitter.sv
bench/tb_ook_pulse_message_transmitter.sv
